[design/wsd_pkg.sv]
// Shared types and constants for the WebSocket receive deframer.
// Used by every module of the block; depends on nothing.
package wsd_pkg;

    localparam int LEN_BITS_DEF = 64;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;

    localparam logic [1:0] WHY_NORMAL      = 2'd0;
    localparam logic [1:0] WHY_PROTOCOL    = 2'd1;
    localparam logic [1:0] WHY_UNSUPPORTED = 2'd2;

    localparam logic [3:0] HDR_FIN_NIBBLE = 4'h8;
    localparam logic [3:0] OP_TEXT        = 4'h1;
    localparam logic [3:0] OP_CLOSE       = 4'h8;
    localparam logic [3:0] OP_PING        = 4'h9;
    localparam logic [6:0] LEN7_EXT16     = 7'd126;
    localparam logic [6:0] LEN7_EXT64     = 7'd127;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] key;
        logic       ping;
        logic       last;
        logic [1:0] reason;
    } t_op;

endpackage

[design/wsd_front.sv]
// Front end of the deframer: header parser, length and mask-key capture.
// Classifies accepted bytes into result records; not every byte yields one. Depends on wsd_pkg.
module wsd_front
    import wsd_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output logic       o_op_valid,
    output t_op        o_op
);

    typedef enum logic [5:0] {
        PH_HDR0   = 6'b000001,
        PH_HDR1   = 6'b000010,
        PH_EXT    = 6'b000100,
        PH_MASK   = 6'b001000,
        PH_DATA   = 6'b010000,
        PH_CLOSED = 6'b100000
    } t_phase;

    t_phase              r_phase, n_phase;
    logic                r_ping, n_ping;
    logic [LEN_BITS-1:0] r_rem, n_rem;
    logic [3:0]          r_ext, n_ext;
    logic [31:0]         r_mask, n_mask;
    logic [1:0]          r_ki, n_ki;

    logic [3:0] w_op;
    logic [6:0] w_len7;
    logic [1:0] w_ki_inc;

    assign w_op     = i_byte[3:0];
    assign w_len7   = i_byte[6:0];
    assign w_ki_inc = r_ki + 2'd1;

    always_comb begin
        n_phase    = r_phase;
        n_ping     = r_ping;
        n_rem      = r_rem;
        n_ext      = r_ext;
        n_mask     = r_mask;
        n_ki       = r_ki;
        o_op_valid = 1'b0;
        o_op       = '{kind: KIND_DATA, data: 8'd0, key: 8'd0, ping: 1'b0,
                       last: 1'b0, reason: WHY_NORMAL};
        unique case (r_phase)
            PH_HDR0: begin
                if (i_byte[7:4] != HDR_FIN_NIBBLE) begin
                    n_phase    = PH_CLOSED;
                    o_op_valid = 1'b1;
                    o_op.kind  = KIND_CLOSE;
                    o_op.reason = WHY_UNSUPPORTED;
                end else if (w_op == OP_CLOSE) begin
                    n_phase    = PH_CLOSED;
                    o_op_valid = 1'b1;
                    o_op.kind  = KIND_CLOSE;
                    o_op.reason = WHY_NORMAL;
                end else if (w_op != OP_TEXT && w_op != OP_PING) begin
                    n_phase    = PH_CLOSED;
                    o_op_valid = 1'b1;
                    o_op.kind  = KIND_CLOSE;
                    o_op.reason = WHY_UNSUPPORTED;
                end else begin
                    n_ping  = (w_op == OP_PING);
                    n_phase = PH_HDR1;
                end
            end
            PH_HDR1: begin
                if (!i_byte[7]) begin
                    n_phase    = PH_CLOSED;
                    o_op_valid = 1'b1;
                    o_op.kind  = KIND_CLOSE;
                    o_op.reason = WHY_PROTOCOL;
                end else begin
                    n_ki   = 2'd0;
                    n_mask = 32'd0;
                    n_rem  = '0;
                    if (w_len7 == LEN7_EXT16) begin
                        n_ext   = 4'd2;
                        n_phase = PH_EXT;
                    end else if (w_len7 == LEN7_EXT64) begin
                        n_ext   = 4'd8;
                        n_phase = PH_EXT;
                    end else begin
                        n_rem   = {{(LEN_BITS-7){1'b0}}, w_len7};
                        n_ext   = 4'd0;
                        n_phase = PH_MASK;
                    end
                end
            end
            PH_EXT: begin
                if (r_rem[LEN_BITS-1 -: 8] != 8'd0) begin
                    n_rem = '1;
                end else begin
                    n_rem = {r_rem[LEN_BITS-9:0], i_byte};
                end
                n_ext = r_ext - 4'd1;
                if (n_ext == 4'd0) begin
                    n_phase = PH_MASK;
                end
            end
            PH_MASK: begin
                n_mask = {r_mask[23:0], i_byte};
                n_ki   = w_ki_inc;
                if (w_ki_inc == 2'd0) begin
                    if (r_rem == '0) begin
                        n_phase    = PH_HDR0;
                        o_op_valid = 1'b1;
                        o_op.kind  = KIND_EMPTY;
                        o_op.ping  = r_ping;
                        o_op.last  = 1'b1;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                n_ki       = w_ki_inc;
                n_rem      = r_rem - LEN_BITS'(1);
                o_op_valid = 1'b1;
                o_op.kind  = KIND_DATA;
                o_op.data  = i_byte;
                o_op.key   = r_mask[{~r_ki, 3'b000} +: 8];
                o_op.ping  = r_ping;
                o_op.last  = (r_rem == LEN_BITS'(1));
                if (r_rem == LEN_BITS'(1)) begin
                    n_phase = PH_HDR0;
                end
            end
            PH_CLOSED: begin
                n_phase = PH_CLOSED;
            end
            default: begin
                n_phase = PH_HDR0;
            end
        endcase
        if (!i_accept) begin
            o_op_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR0;
            r_ping  <= 1'b0;
            r_rem   <= '0;
            r_ext   <= 4'd0;
            r_mask  <= 32'd0;
            r_ki    <= 2'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_ping  <= n_ping;
            r_rem   <= n_rem;
            r_ext   <= n_ext;
            r_mask  <= n_mask;
            r_ki    <= n_ki;
        end
    end

endmodule

[design/wsd_queue.sv]
// Short queue of classified result records between front and back end.
// Register array with read and write pointers. Depends on wsd_pkg.
module wsd_queue
    import wsd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_op  i_wr_op,
    input  logic i_rd,
    output t_op  o_rd_op,
    output logic o_nonempty,
    output logic o_full
);

    t_op               r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;

    assign o_rd_op    = r_mem[r_rp];
    assign o_nonempty = (r_cnt != '0);
    assign o_full     = (r_cnt == (QPTR_W+1)'(QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wr_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_rd) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            r_cnt <= r_cnt + (QPTR_W+1)'(i_wr) - (QPTR_W+1)'(i_rd);
        end
    end

endmodule

[design/wsd_back.sv]
// Back end of the deframer: unmasks payload bytes and holds the output beat.
// Output register with its own valid flag. Depends on wsd_pkg.
module wsd_back
    import wsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_op_valid,
    input  t_op        i_op,
    output logic       o_take,
    input  logic       i_pop,
    output logic       o_valid,
    output logic [1:0] o_kind,
    output logic [7:0] o_data_byte,
    output logic       o_is_ping,
    output logic       o_last,
    output logic [1:0] o_close_reason
);

    logic       r_valid;
    logic [1:0] r_kind;
    logic [7:0] r_data;
    logic       r_ping;
    logic       r_last;
    logic [1:0] r_reason;

    assign o_take = i_op_valid && (!r_valid || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_kind   <= i_op.kind;
            r_data   <= i_op.data ^ i_op.key;
            r_ping   <= i_op.ping;
            r_last   <= i_op.last;
            r_reason <= i_op.reason;
        end
    end

    assign o_valid        = r_valid;
    assign o_kind         = r_kind;
    assign o_data_byte    = r_data;
    assign o_is_ping      = r_ping;
    assign o_last         = r_last;
    assign o_close_reason = r_reason;

endmodule

[design/websocket_frame_deframe.sv]
// Channel   | Handshake          | Beat contents
// input     | i_push / o_full    | i_rx_byte: one received stream byte
// result    | o_empty / i_pop    | o_kind, o_data_byte, o_is_ping, o_last, o_close_reason
//
// One byte is taken every cycle while o_full is low; a result reaches the outputs
// through a four-entry queue and an output register.
// o_full rises when the queue holds four records, so a stalled reader stops input once five
// results wait, four in the queue and one in the output register.
// Reset is synchronous and clears the parser state, the queue and the output register.
// Top level of the WebSocket receive deframer; depends on wsd_pkg and the wsd_* modules.
module websocket_frame_deframe
    import wsd_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_rx_byte,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [1:0] o_kind,
    output logic [7:0] o_data_byte,
    output logic       o_is_ping,
    output logic       o_last,
    output logic [1:0] o_close_reason
);

    logic w_accept;
    logic w_op_valid;
    t_op  w_op;
    t_op  w_q_op;
    logic w_q_nonempty;
    logic w_take;
    logic w_valid;

    assign w_accept = i_push && !o_full;
    assign o_empty  = !w_valid;

    wsd_front #(
        .LEN_BITS(LEN_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_byte     (i_rx_byte),
        .o_op_valid (w_op_valid),
        .o_op       (w_op)
    );

    wsd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_op_valid),
        .i_wr_op    (w_op),
        .i_rd       (w_take),
        .o_rd_op    (w_q_op),
        .o_nonempty (w_q_nonempty),
        .o_full     (o_full)
    );

    wsd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op_valid     (w_q_nonempty),
        .i_op           (w_q_op),
        .o_take         (w_take),
        .i_pop          (i_pop),
        .o_valid        (w_valid),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_is_ping      (o_is_ping),
        .o_last         (o_last),
        .o_close_reason (o_close_reason)
    );

endmodule

[design/wsd_checker.sv]
// Port-level checker for the WebSocket receive deframer, bound to the top level.
// Depends on wsd_pkg for the result kind and close reason codes.
module wsd_checker
    import wsd_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_pop,
    input logic       o_full,
    input logic       o_empty,
    input logic [1:0] o_kind,
    input logic [7:0] o_data_byte,
    input logic       o_is_ping,
    input logic       o_last,
    input logic [1:0] o_close_reason
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty && !o_full)
        else $error("Queue or output not cleared by reset.");

    a_close_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_kind == KIND_CLOSE |->
            !o_is_ping && !o_last && o_data_byte == 8'd0 &&
            (o_close_reason == WHY_NORMAL || o_close_reason == WHY_PROTOCOL ||
             o_close_reason == WHY_UNSUPPORTED))
        else $error("Close beat carries stray fields.");

    a_marker_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_kind == KIND_EMPTY |->
            o_last && o_data_byte == 8'd0 && o_close_reason == WHY_NORMAL)
        else $error("Empty-frame marker malformed.");

    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> o_kind == KIND_DATA || o_kind == KIND_EMPTY ||
            o_kind == KIND_CLOSE)
        else $error("Undefined result kind.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_kind) && $stable(o_data_byte)
            && $stable(o_last))
        else $error("Stalled result beat changed.");

endmodule

bind websocket_frame_deframe wsd_checker u_wsd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_pop          (i_pop),
    .o_full         (o_full),
    .o_empty        (o_empty),
    .o_kind         (o_kind),
    .o_data_byte    (o_data_byte),
    .o_is_ping      (o_is_ping),
    .o_last         (o_last),
    .o_close_reason (o_close_reason)
);
